// ===== hw/rtl/key_repeat_and_chord_qualifier_defines.svh =====
// ----------------------------------------------------------------------------
// Keypad qualifier assertion macros
// Shared concurrent assertion forms used by the keypad qualifier RTL.
// Each macro expects signals named clk and rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef KEY_REPEAT_AND_CHORD_QUALIFIER_DEFINES_SVH
`define KEY_REPEAT_AND_CHORD_QUALIFIER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KRCQ_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KRCQ_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/krcq_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad qualifier package
// Widths, register indexes, item and result types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package krcq_pkg;

  // Number of keys on the pad and the fixed field widths.
  localparam int NUM_KEYS  = 10;
  localparam int FIELD_W   = 10;
  localparam int CNT_W     = 8;
  localparam int REG_IDX_W = 2;

  // Keys that can actually be sampled fit inside the key field.
  localparam int KEY_LANES = (NUM_KEYS < FIELD_W) ? NUM_KEYS : FIELD_W;
  localparam logic [FIELD_W-1:0] KEY_MASK = FIELD_W'((1 << KEY_LANES) - 1);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_TOP    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_RELOAD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TAP_HOLD      = 2'd2;

  // Configuration reset values.
  localparam logic [CNT_W-1:0] RST_REPEAT_TOP    = 8'd32;
  localparam logic [CNT_W-1:0] RST_REPEAT_RELOAD = 8'd29;
  localparam logic [CNT_W-1:0] RST_TAP_HOLD      = 8'd5;

  typedef enum logic [0:0] {
    KIND_TICK  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CNT_W-1:0] repeat_top;
    logic [CNT_W-1:0] repeat_reload;
    logic [CNT_W-1:0] tap_hold_frames;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [FIELD_W-1:0] keys;
    logic [FIELD_W-1:0] key_a;
    logic [FIELD_W-1:0] key_b;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] held_now;
    logic [FIELD_W-1:0] pressed_now;
    logic [FIELD_W-1:0] repeat_now;
    logic [FIELD_W-1:0] chord_result;
  } result_t;

  // Per-key flags that one counter lane reports to the query logic.
  typedef struct packed {
    logic hold_eq_tap;
    logic rel_one;
    logic rel_two;
    logic rep_fire;
  } lane_stat_t;

  // True when the mask names exactly one key that exists on the pad.
  function automatic logic key_valid(input logic [FIELD_W-1:0] mask);
    key_valid = (mask != '0) && ((mask & (mask - 1'b1)) == '0) &&
                ((mask & ~KEY_MASK) == '0);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/krcq_if.sv =====
// ----------------------------------------------------------------------------
// Keypad qualifier channels
// Valid/ready channels for request beats, result beats and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface krcq_req_if;
  import krcq_pkg::*;
  logic               valid;
  logic               ready;
  logic [0:0]         kind;
  logic [FIELD_W-1:0] keys;
  logic [FIELD_W-1:0] key_a;
  logic [FIELD_W-1:0] key_b;

  modport source (output valid, kind, keys, key_a, key_b, input ready);
  modport sink   (input valid, kind, keys, key_a, key_b, output ready);
endinterface

interface krcq_rsp_if;
  import krcq_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] held_now;
  logic [FIELD_W-1:0] pressed_now;
  logic [FIELD_W-1:0] repeat_now;
  logic [FIELD_W-1:0] chord_result;

  modport source (output valid, held_now, pressed_now, repeat_now, chord_result,
                  input ready);
  modport sink   (input valid, held_now, pressed_now, repeat_now, chord_result,
                  output ready);
endinterface

interface krcq_cfg_if;
  import krcq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index;
  logic [CNT_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/key_repeat_and_chord_qualifier.sv =====
// ----------------------------------------------------------------------------
// Keypad auto-repeat and chord qualifier
// Qualifies a small keypad: per-key repeat timing and two-key chord queries.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per item: kind selects a frame tick (keys holds the
//   raw key sample) or a chord query (key_a and key_b name one key each).
//   rsp returns exactly one beat per request beat, in order, with the held,
//   newly pressed and repeat masks and the chord answer (zero for ticks).
//   cfg writes repeat_top, repeat_reload and tap_hold_frames by reg_index;
//   it is always ready; the user must write it only while idle, unchecked by the block.
// Timing:
//   A request beat is registered at the input, processed by the key lanes and
//   the chord logic once the result register is free or drains, and lands in
//   the result register. One beat per cycle is sustained while rsp is ready,
//   with all ten key lanes updating together.
// Reset and stall:
//   rst (synchronous) clears all key masks and the chord latch, sets hold
//   counts to zero and release counts to 255, and loads default registers.
//   While rsp is stalled the result register holds, one more request waits in
//   the input register, and req.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_repeat_and_chord_qualifier_defines.svh"

module key_repeat_and_chord_qualifier (
  input  wire logic  clk,
  input  wire logic  rst,
  krcq_req_if.sink   req,
  krcq_rsp_if.source rsp,
  krcq_cfg_if.sink   cfg
);
  import krcq_pkg::*;

  cfg_t    cfg_regs;
  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t result;
  result_t out_result;
  logic    out_valid;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.repeat_top      <= RST_REPEAT_TOP;
      cfg_regs.repeat_reload   <= RST_REPEAT_RELOAD;
      cfg_regs.tap_hold_frames <= RST_TAP_HOLD;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_REPEAT_TOP:    cfg_regs.repeat_top      <= cfg.wdata;
        REG_REPEAT_RELOAD: cfg_regs.repeat_reload   <= cfg.wdata;
        REG_TAP_HOLD:      cfg_regs.tap_hold_frames <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // The held beat moves on whenever the result register is free or drains.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.kind  <= kind_e'(req.kind);
      in_item.keys  <= req.keys;
      in_item.key_a <= req.key_a;
      in_item.key_b <= req.key_b;
    end
  end

  krcq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg_regs),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.held_now     = out_result.held_now;
  assign rsp.pressed_now  = out_result.pressed_now;
  assign rsp.repeat_now   = out_result.repeat_now;
  assign rsp.chord_result = out_result.chord_result;

  // A waiting beat is never dropped while the result side is stalled.
  `KRCQ_CHECK_NEXT(a_top_hold_input, in_valid && !advance, in_valid, "top: waiting beat lost")
  // Every result beat shows newly pressed keys only among held keys.
  `KRCQ_CHECK(a_top_pressed_held, out_valid, (rsp.pressed_now & ~rsp.held_now) == '0, "top: pressed key not held in result")

endmodule

`default_nettype wire

// ===== hw/rtl/krcq_lane.sv =====
// ----------------------------------------------------------------------------
// Keypad qualifier key lane
// Hold and release frame counters of one key, with its repeat and query flags.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_repeat_and_chord_qualifier_defines.svh"

module krcq_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                tick,
  input  wire logic                key_down,
  input  wire krcq_pkg::cfg_t      cfg,
  output krcq_pkg::lane_stat_t     stat
);
  import krcq_pkg::*;

  logic [CNT_W-1:0] hold_count;
  logic [CNT_W-1:0] hold_count_next;
  logic [CNT_W-1:0] release_count;
  logic [CNT_W-1:0] release_count_next;
  logic [CNT_W:0]   hold_inc;

  // Next counts for a frame tick: a held key counts up and wraps past the
  // repeat top, a released key counts released frames up to saturation.
  always_comb begin
    hold_inc = {1'b0, hold_count} + 1'b1;
    if (key_down) begin
      hold_count_next    = (hold_inc > {1'b0, cfg.repeat_top}) ?
                           cfg.repeat_reload : hold_inc[CNT_W-1:0];
      release_count_next = '0;
    end else begin
      hold_count_next    = '0;
      release_count_next = (release_count == CNT_MAX) ?
                           release_count : release_count + 1'b1;
    end
  end

  // Counter registers, updated only on frame ticks.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count    <= '0;
      release_count <= CNT_MAX;
    end else if (tick) begin
      hold_count    <= hold_count_next;
      release_count <= release_count_next;
    end
  end

  // Flags: repeat uses the new count, query flags use the stored counts.
  always_comb begin
    stat.rep_fire    = (hold_count_next == CNT_W'(1)) ||
                       (hold_count_next == cfg.repeat_top);
    stat.hold_eq_tap = (hold_count == cfg.tap_hold_frames);
    stat.rel_one     = (release_count == CNT_W'(1));
    stat.rel_two     = (release_count == CNT_W'(2));
  end

  // A key is either counting held frames or released frames, never both.
  `KRCQ_CHECK(a_lane_exclusive, 1'b1, (hold_count == '0) || (release_count == '0), "lane: hold and release counts both nonzero")

endmodule

`default_nettype wire

// ===== hw/rtl/krcq_core.sv =====
// ----------------------------------------------------------------------------
// Keypad qualifier core
// Key masks, chord latch and the per-key lanes; computes one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_repeat_and_chord_qualifier_defines.svh"

module krcq_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire krcq_pkg::item_t  item,
  input  wire krcq_pkg::cfg_t   cfg,
  output krcq_pkg::result_t     result
);
  import krcq_pkg::*;

  logic [FIELD_W-1:0] held_bits;
  logic [FIELD_W-1:0] pressed_bits;
  logic [FIELD_W-1:0] repeat_bits;
  logic [FIELD_W-1:0] chord_latch;
  logic [FIELD_W-1:0] chord_latch_next;

  logic               is_tick;
  logic               tick;
  logic [FIELD_W-1:0] keys_m;

  lane_stat_t         stat [KEY_LANES];
  logic [FIELD_W-1:0] rep_vec;
  logic [FIELD_W-1:0] tap_vec;
  logic [FIELD_W-1:0] rel1_vec;
  logic [FIELD_W-1:0] rel2_vec;

  logic               a_ok;
  logic               b_ok;
  logic               a_tap;
  logic               b_tap;
  logic               a_rel1;
  logic               b_rel1;
  logic               a_rel2;
  logic               b_rel2;
  logic [FIELD_W-1:0] latch_clr;
  logic [FIELD_W-1:0] latch_chord;
  logic [FIELD_W-1:0] latch_a;
  logic [FIELD_W-1:0] answer;
  logic [FIELD_W-1:0] answer_chord;
  logic [FIELD_W-1:0] answer_a;
  logic               chord_hit;

  assign is_tick = (item.kind == KIND_TICK);
  assign tick    = advance && is_tick;
  assign keys_m  = item.keys & KEY_MASK;

  // One counter lane per key.
  for (genvar i = 0; i < KEY_LANES; i++) begin : g_lane
    krcq_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .tick     (tick),
      .key_down (keys_m[i]),
      .cfg      (cfg),
      .stat     (stat[i])
    );
  end

  // Gather lane flags into key-ordered vectors.
  always_comb begin
    rep_vec  = '0;
    tap_vec  = '0;
    rel1_vec = '0;
    rel2_vec = '0;
    for (int i = 0; i < KEY_LANES; i++) begin
      rep_vec[i]  = stat[i].rep_fire;
      tap_vec[i]  = stat[i].hold_eq_tap;
      rel1_vec[i] = stat[i].rel_one;
      rel2_vec[i] = stat[i].rel_two;
    end
  end

  // Count lookups for the query keys. A key that is not a single pad key
  // reads hold and release counts of zero.
  always_comb begin
    a_ok   = key_valid(item.key_a);
    b_ok   = key_valid(item.key_b);
    a_tap  = a_ok ? |(item.key_a & tap_vec) : (cfg.tap_hold_frames == '0);
    b_tap  = b_ok ? |(item.key_b & tap_vec) : (cfg.tap_hold_frames == '0);
    a_rel1 = a_ok && |(item.key_a & rel1_vec);
    b_rel1 = b_ok && |(item.key_b & rel1_vec);
    a_rel2 = a_ok && |(item.key_a & rel2_vec);
    b_rel2 = b_ok && |(item.key_b & rel2_vec);
  end

  // Chord query: release clear, chord detection, then single-key reports
  // for the first key and the second key, the later report winning.
  always_comb begin
    latch_clr = chord_latch;
    if (a_rel2) begin
      latch_clr = latch_clr & ~item.key_a;
    end
    if (b_rel2) begin
      latch_clr = latch_clr & ~item.key_b;
    end

    chord_hit = (|(pressed_bits & item.key_a) && |(held_bits & item.key_b)) ||
                (|(pressed_bits & item.key_b) && |(held_bits & item.key_a));
    latch_chord  = chord_hit ? (latch_clr | item.key_a | item.key_b) : latch_clr;
    answer_chord = chord_hit ? (item.key_a | item.key_b) : '0;

    latch_a  = latch_chord;
    answer_a = answer_chord;
    if (((latch_chord & item.key_a) == '0) && (a_tap || a_rel1)) begin
      latch_a  = latch_chord | item.key_a;
      answer_a = item.key_a;
    end

    chord_latch_next = latch_a;
    answer           = answer_a;
    if (((latch_a & item.key_b) == '0) && (b_tap || b_rel1)) begin
      chord_latch_next = latch_a | item.key_b;
      answer           = item.key_b;
    end
  end

  // Key state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_bits    <= '0;
      pressed_bits <= '0;
      repeat_bits  <= '0;
      chord_latch  <= '0;
    end else if (advance) begin
      if (is_tick) begin
        pressed_bits <= keys_m & ~held_bits;
        held_bits    <= keys_m;
        repeat_bits  <= rep_vec;
      end else begin
        chord_latch  <= chord_latch_next;
      end
    end
  end

  // Result of the beat being processed, as the state reads after it.
  always_comb begin
    if (is_tick) begin
      result.held_now     = keys_m;
      result.pressed_now  = keys_m & ~held_bits;
      result.repeat_now   = rep_vec;
      result.chord_result = '0;
    end else begin
      result.held_now     = held_bits;
      result.pressed_now  = pressed_bits;
      result.repeat_now   = repeat_bits;
      result.chord_result = answer;
    end
  end

  // A newly pressed key is always among the held keys.
  `KRCQ_CHECK(a_core_pressed_held, 1'b1, (pressed_bits & ~held_bits) == '0, "core: pressed key not held")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Keypad qualifier testbench
// Drives frame ticks and chord queries into the keypad qualifier, tracks the
// expected held, pressed, repeat and chord masks in a local model of the
// per-key counters, and compares every result beat in order. The run walks
// through several repeat and tap-hold settings, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import krcq_pkg::*;

  // Register index that the block has no register for.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  // How the result side paces its ready line.
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PATTERN,
    RDY_MOSTLY
  } ready_mode_e;

  logic clk;
  logic rst;

  krcq_req_if req_ch ();
  krcq_rsp_if rsp_ch ();
  krcq_cfg_if cfg_ch ();

  key_repeat_and_chord_qualifier dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Beats waiting to be sent and the results they are expected to produce.
  item_t   key_beats[$];
  result_t due_reports[$];
  int      n_planned = 0;
  int      n_checked = 0;
  int      n_errors  = 0;

  // Keypad model: masks, per-key counters and register copies.
  logic [FIELD_W-1:0] pad_held;
  logic [FIELD_W-1:0] pad_pressed;
  logic [FIELD_W-1:0] pad_repeat;
  logic [FIELD_W-1:0] pad_latch;
  logic [CNT_W-1:0]   pad_hold [NUM_KEYS];
  logic [CNT_W-1:0]   pad_rel  [NUM_KEYS];
  logic [CNT_W-1:0]   pad_top;
  logic [CNT_W-1:0]   pad_reload;
  logic [CNT_W-1:0]   pad_tap;

  // Generator state: the keys a player currently holds and the last one moved.
  logic [FIELD_W-1:0] gen_keys  = '0;
  int                 last_lane = 0;

  // Lane of a mask naming exactly one key on the pad, or -1.
  function automatic int key_lane(input logic [FIELD_W-1:0] m);
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (m == (FIELD_W'(1) << i)) return i;
    end
    return -1;
  endfunction

  // Applies one item to the keypad model and returns the result it causes.
  function automatic result_t qualify(input item_t it);
    result_t            res;
    logic [FIELD_W-1:0] k;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] ans;
    logic [CNT_W:0]     nxt;
    logic [CNT_W-1:0]   ha;
    logic [CNT_W-1:0]   hb;
    logic [CNT_W-1:0]   ca;
    logic [CNT_W-1:0]   cb;
    int                 la;
    int                 lb;
    ans = '0;
    if (it.kind == KIND_TICK) begin
      k           = it.keys & KEY_MASK;
      pad_pressed = k & ~pad_held & KEY_MASK;
      pad_held    = k;
      pad_repeat  = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (k[i]) begin
          // Count held frames at 9 bits; going past the top reloads.
          nxt = {1'b0, pad_hold[i]} + 1'b1;
          if (nxt > {1'b0, pad_top}) nxt = {1'b0, pad_reload};
          pad_hold[i] = nxt[CNT_W-1:0];
          pad_rel[i]  = '0;
        end else begin
          pad_hold[i] = '0;
          if (pad_rel[i] != CNT_MAX) pad_rel[i] = pad_rel[i] + 1'b1;
        end
        if (pad_hold[i] == 8'd1 || pad_hold[i] == pad_top) pad_repeat[i] = 1'b1;
      end
    end else begin
      a  = it.key_a;
      b  = it.key_b;
      la = key_lane(a);
      lb = key_lane(b);
      // Masks that do not name one key read zero counts.
      ha = (la < 0) ? '0 : pad_hold[la];
      hb = (lb < 0) ? '0 : pad_hold[lb];
      ca = (la < 0) ? '0 : pad_rel[la];
      cb = (lb < 0) ? '0 : pad_rel[lb];
      // The second released frame frees the latch.
      if (ca == 8'd2) pad_latch &= ~a;
      if (cb == 8'd2) pad_latch &= ~b;
      // A fresh press while the other key is held makes a chord.
      if (((pad_pressed & a) != '0 && (pad_held & b) != '0) ||
          ((pad_pressed & b) != '0 && (pad_held & a) != '0)) begin
        pad_latch |= a | b;
        ans = a | b;
      end
      // Otherwise a key reports alone on the tap-hold count or its first release.
      if ((pad_latch & a) == '0 && (ha == pad_tap || ca == 8'd1)) begin
        pad_latch |= a;
        ans = a;
      end
      if ((pad_latch & b) == '0 && (hb == pad_tap || cb == 8'd1)) begin
        pad_latch |= b;
        ans = b;
      end
    end
    res.held_now     = pad_held;
    res.pressed_now  = pad_pressed;
    res.repeat_now   = pad_repeat;
    res.chord_result = ans;
    return res;
  endfunction

  // Model update on each register write and each accepted request beat.
  always @(posedge clk) begin : track_pad
    item_t seen;
    if (rst) begin
      pad_held    = '0;
      pad_pressed = '0;
      pad_repeat  = '0;
      pad_latch   = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        pad_hold[i] = '0;
        pad_rel[i]  = CNT_MAX;
      end
      pad_top    = RST_REPEAT_TOP;
      pad_reload = RST_REPEAT_RELOAD;
      pad_tap    = RST_TAP_HOLD;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_REPEAT_TOP:    pad_top    = cfg_ch.wdata;
          REG_REPEAT_RELOAD: pad_reload = cfg_ch.wdata;
          REG_TAP_HOLD:      pad_tap    = cfg_ch.wdata;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.kind  = kind_e'(req_ch.kind);
        seen.keys  = req_ch.keys;
        seen.key_a = req_ch.key_a;
        seen.key_b = req_ch.key_b;
        due_reports.push_back(qualify(seen));
      end
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_beats
    item_t beat;
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap_left > 0 || key_beats.size() == 0) begin
        if (gap_left > 0) gap_left--;
        req_ch.valid <= 1'b0;
      end else begin
        beat = key_beats.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.kind  <= beat.kind;
        req_ch.keys  <= beat.keys;
        req_ch.key_a <= beat.key_a;
        req_ch.key_b <= beat.key_b;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(0, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // Result-side ready: changing stall modes, plus one long hold-off once the
  // block has been busy for a while, so that it backs up into the request side.
  int          taken_cnt      = 0;
  int          hold_off_left  = 0;
  bit          long_hold_done = 1'b0;
  int          mode_left      = 0;
  ready_mode_e stall_mode     = RDY_ALWAYS;
  logic [15:0] stall_pat      = 16'h00FF;

  always @(posedge clk) begin : drive_ready
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) taken_cnt++;
      if (hold_off_left == 0 && !long_hold_done && taken_cnt >= 400) begin
        hold_off_left  = 180;
        long_hold_done = 1'b1;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = ready_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(16, 96);
          stall_pat  = 16'($urandom) | 16'h0001;
        end else begin
          mode_left--;
        end
        case (stall_mode)
          RDY_ALWAYS: rsp_ch.ready <= 1'b1;
          RDY_COIN:   rsp_ch.ready <= 1'($urandom);
          RDY_PATTERN: begin
            stall_pat = {stall_pat[14:0], stall_pat[15]};
            rsp_ch.ready <= stall_pat[0];
          end
          default:    rsp_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic void compare_field(input string name,
                                        input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      n_errors++;
    end
  endfunction

  // Result monitor: each result beat against the oldest expectation.
  always @(posedge clk) begin : check_reports
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_reports.size() == 0) begin
        $error("result beat with no request pending: held_now %h", rsp_ch.held_now);
        n_errors++;
      end else begin
        want = due_reports.pop_front();
        compare_field("held_now", want.held_now, rsp_ch.held_now);
        compare_field("pressed_now", want.pressed_now, rsp_ch.pressed_now);
        compare_field("repeat_now", want.repeat_now, rsp_ch.repeat_now);
        compare_field("chord_result", want.chord_result, rsp_ch.chord_result);
        n_checked++;
      end
    end
  end

  // Unused fields of every beat carry random bits.
  function automatic void add_tick(input logic [FIELD_W-1:0] keys);
    item_t it;
    it.kind  = KIND_TICK;
    it.keys  = keys;
    it.key_a = FIELD_W'($urandom);
    it.key_b = FIELD_W'($urandom);
    key_beats.push_back(it);
    n_planned++;
  endfunction

  function automatic void add_query(input logic [FIELD_W-1:0] a,
                                    input logic [FIELD_W-1:0] b);
    item_t it;
    it.kind  = KIND_QUERY;
    it.keys  = FIELD_W'($urandom);
    it.key_a = a;
    it.key_b = b;
    key_beats.push_back(it);
    n_planned++;
  endfunction

  // Query keys lean toward the key that just moved and keys being held.
  function automatic logic [FIELD_W-1:0] pick_query_key();
    int r;
    int lane;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return FIELD_W'($urandom);
    if (r < 8) return FIELD_W'(1) << last_lane;
    if (r < 13 && gen_keys != '0) begin
      lane = $urandom_range(0, NUM_KEYS - 1);
      while (!gen_keys[lane]) lane = (lane + 1) % NUM_KEYS;
      return FIELD_W'(1) << lane;
    end
    return FIELD_W'(1) << $urandom_range(0, NUM_KEYS - 1);
  endfunction

  // A stretch of play: keys change one at a time, with queries in between.
  // Large flip odds give long holds and long releases; noise ticks jump to a
  // random key sample for one frame.
  task automatic plan_session(input int count, input int flip_odds,
                              input int tick_pct, input bit noise);
    logic [FIELD_W-1:0] a;
    repeat (count) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        if (noise && $urandom_range(0, 24) == 0) begin
          add_tick(FIELD_W'($urandom));
        end else begin
          if ($urandom_range(1, flip_odds) == 1) begin
            last_lane = $urandom_range(0, NUM_KEYS - 1);
            gen_keys[last_lane] = ~gen_keys[last_lane];
          end
          add_tick(gen_keys);
        end
      end else begin
        a = pick_query_key();
        if ($urandom_range(0, 9) == 0) add_query(a, a);
        else add_query(a, pick_query_key());
      end
    end
  endtask

  // Waits until every planned beat has its result, then lets the block settle.
  task automatic drain();
    while (n_checked != n_planned) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [CNT_W-1:0] top, input logic [CNT_W-1:0] reload,
                            input logic [CNT_W-1:0] tap);
    write_reg(REG_REPEAT_TOP, top);
    write_reg(REG_REPEAT_RELOAD, reload);
    write_reg(REG_TAP_HOLD, tap);
  endtask

  // Main sequence: reset, directed beats, then phases with different settings.
  initial begin : stimulus
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wdata     = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings.
    add_tick('0);
    add_tick(10'h3FF);             // every key pressed at once, all repeat
    add_query(10'h001, 10'h002);   // chord of two fresh presses
    add_query('0, '0);             // empty masks
    add_query(10'h003, 10'h200);   // several bits in one mask
    repeat (4) add_tick(10'h3FF);  // hold reaches the tap-hold count
    add_query(10'h010, 10'h020);   // both report alone, later one wins
    add_query(10'h010, 10'h020);   // already latched
    add_tick('0);                  // first released frame
    add_query(10'h200, 10'h100);
    add_tick('0);                  // second released frame frees the latch
    add_query(10'h200, 10'h010);
    add_query(10'h3FF, '0);
    add_tick(10'h001);
    add_query(10'h002, 10'h001);
    add_tick(10'h003);
    add_query(10'h002, 10'h001);   // fresh press while the other is held
    add_query(10'h001, 10'h001);   // same key twice
    gen_keys = 10'h003;
    plan_session(180, 6, 60, 1'b1);
    drain();

    // Lowest repeat top, reload and tap-hold count.
    set_timing(8'd2, 8'd1, 8'd1);
    plan_session(170, 4, 60, 1'b1);
    drain();

    // Values outside the usual range, and a write to a missing register.
    set_timing(8'd255, 8'd0, 8'd0);
    write_reg(REG_SPARE, 8'hA5);
    gen_keys = 10'h155;
    plan_session(330, 150, 90, 1'b0);
    drain();

    // Highest usual settings; long holds reach the top and wrap.
    set_timing(8'd254, 8'd253, 8'd254);
    gen_keys |= 10'h0A2;
    plan_session(300, 150, 90, 1'b0);
    drain();

    // Random settings inside the usual range.
    set_timing(8'($urandom_range(2, 254)), 8'($urandom_range(1, 253)),
               8'($urandom_range(1, 10)));
    plan_session(150, 5, 60, 1'b1);
    drain();

    repeat (8) @(posedge clk);
    if (due_reports.size() != 0) begin
      $error("%0d expected results never arrived", due_reports.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("key_repeat_and_chord_qualifier: match");
    end else begin
      $display("key_repeat_and_chord_qualifier: mismatch");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    #(2_000_000);
    $display("key_repeat_and_chord_qualifier: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ===== key_repeat_and_chord_qualifier.f =====
+incdir+hw/rtl
hw/rtl/krcq_pkg.sv
hw/rtl/krcq_if.sv
hw/rtl/krcq_lane.sv
hw/rtl/krcq_core.sv
hw/rtl/key_repeat_and_chord_qualifier.sv
sim/tb_top.sv
